// File: rtl/caldate_pkg.sv
// Shared types, constants and helpers for the calendar date counter.
`default_nettype none

package caldate_pkg;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_INC = 2'd1;
    localparam logic [1:0] OP_ADD = 2'd2;

    // Date limits
    localparam logic [11:0] YEAR_FIRST    = 12'd1980;
    localparam logic [11:0] YEAR_LAST_SET = 12'd2100;
    localparam logic [11:0] YEAR_TOP      = 12'd4095;
    localparam logic [11:0] YEAR_BASE     = 12'd1900;
    localparam logic [3:0]  MONTH_LAST    = 4'd12;
    localparam logic [4:0]  DAY_LAST_DEC  = 5'd31;
    localparam logic [4:0]  DAY_FEB_LEAP  = 5'd29;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [6:0]  YEAR_IN_CENT_LAST = 7'd99;

    // Default clamp on a day count
    localparam int MAX_ADD_DAYS_DEF = 65535;

    // Widths of the request and result fields
    localparam int CNT_W = 16;

    // Command from controller to datapath
    typedef struct packed {
        logic load_set;   // try to load the requested date
        logic step;       // advance one day
        logic load_cnt;   // load the clamped day count
        logic dec_cnt;    // count one day off
        logic load_out;   // capture the result into the output register
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic cnt_zero;   // no days left to add
        logic at_top;     // date sits at the last representable day
    } dp_stat_t;

    // Length of a month in a common year; codes past December read as 31
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd0:    len = 5'd0;
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Length of a month with February stretched in leap years
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m == MONTH_FEB && leap)
        begin
            len = DAY_FEB_LEAP;
        end
        else
        begin
            len = month_len(m);
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// File: rtl/caldate_dp.sv
// Datapath of the calendar date counter: date, leap tracking, day count, result register.
`default_nettype none

module caldate_dp #(
    parameter int MAX_ADD_DAYS = caldate_pkg::MAX_ADD_DAYS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire caldate_pkg::dp_cmd_t         cmd,
    output caldate_pkg::dp_stat_t             stat,
    input  wire logic [3:0]                   set_month,
    input  wire logic [4:0]                   set_day,
    input  wire logic [11:0]                  set_year,
    input  wire logic [caldate_pkg::CNT_W-1:0] add_count,
    output logic [3:0]                        cur_month,
    output logic [4:0]                        cur_day,
    output logic [11:0]                       cur_year,
    output logic                              rejected
);

    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [11:0] year_reg, year_next;
    // year within its century and century modulo four, for the leap rule
    logic [6:0]  yic_reg, yic_next;
    logic [1:0]  cent_reg, cent_next;
    logic [caldate_pkg::CNT_W-1:0] cnt_reg, cnt_next, cnt_load;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic [11:0] out_year_reg;
    logic        out_rej_reg;

    logic        cur_leap, set_leap, set_ok, at_top;
    logic [4:0]  cur_len;
    logic [11:0] set_off;
    logic [6:0]  set_yic;
    logic [1:0]  set_cent;

    // Leap flags: current year from century counters, requested year within set range
    assign cur_leap = (year_reg[1:0] == 2'd0) && ((yic_reg != 7'd0) || (cent_reg == 2'd0));
    assign set_leap = (set_year[1:0] == 2'd0) && (set_year != caldate_pkg::YEAR_LAST_SET);
    assign cur_len  = caldate_pkg::days_in(month_reg, cur_leap);

    // Validate the requested date
    assign set_ok = (set_year inside {[caldate_pkg::YEAR_FIRST:caldate_pkg::YEAR_LAST_SET]})
                 && (set_month inside {[4'd1:caldate_pkg::MONTH_LAST]})
                 && (set_day != 5'd0)
                 && (set_day <= caldate_pkg::days_in(set_month, set_leap));

    // Split the requested year into century counters (years 1980 to 2100 only)
    assign set_off = set_year - caldate_pkg::YEAR_BASE;
    always_comb
    begin
        if (set_off >= 12'd200)
        begin
            set_yic  = 7'(set_off - 12'd200);
            set_cent = 2'd1;   // 21: 21 mod 4
        end
        else if (set_off >= 12'd100)
        begin
            set_yic  = 7'(set_off - 12'd100);
            set_cent = 2'd0;   // 20: 20 mod 4
        end
        else
        begin
            set_yic  = 7'(set_off);
            set_cent = 2'd3;   // 19: 19 mod 4
        end
    end

    assign at_top = (year_reg == caldate_pkg::YEAR_TOP)
                 && (month_reg == caldate_pkg::MONTH_LAST)
                 && (day_reg == caldate_pkg::DAY_LAST_DEC);

    // Next date: load, advance one day, or hold
    always_comb
    begin
        month_next = month_reg;
        day_next   = day_reg;
        year_next  = year_reg;
        yic_next   = yic_reg;
        cent_next  = cent_reg;
        if (cmd.load_set && set_ok)
        begin
            month_next = set_month;
            day_next   = set_day;
            year_next  = set_year;
            yic_next   = set_yic;
            cent_next  = set_cent;
        end
        else if (cmd.step && !at_top)
        begin
            if (day_reg < cur_len)
            begin
                day_next = day_reg + 5'd1;
            end
            else if (month_reg < caldate_pkg::MONTH_LAST)
            begin
                month_next = month_reg + 4'd1;
                day_next   = 5'd1;
            end
            else
            begin
                year_next  = year_reg + 12'd1;
                month_next = 4'd1;
                day_next   = 5'd1;
                if (yic_reg == caldate_pkg::YEAR_IN_CENT_LAST)
                begin
                    yic_next  = 7'd0;
                    cent_next = cent_reg + 2'd1;
                end
                else
                begin
                    yic_next = yic_reg + 7'd1;
                end
            end
        end
    end

    // Clamp the requested day count
    assign cnt_load = (32'(add_count) > 32'(MAX_ADD_DAYS))
                    ? caldate_pkg::CNT_W'(MAX_ADD_DAYS) : add_count;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load_cnt)
        begin
            cnt_next = cnt_load;
        end
        else if (cmd.dec_cnt)
        begin
            cnt_next = cnt_reg - caldate_pkg::CNT_W'(1);
        end
    end

    // Date and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            month_reg <= 4'd1;
            day_reg   <= 5'd1;
            year_reg  <= caldate_pkg::YEAR_FIRST;
            yic_reg   <= 7'd80;
            cent_reg  <= 2'd3;
            cnt_reg   <= '0;
        end
        else
        begin
            month_reg <= month_next;
            day_reg   <= day_next;
            year_reg  <= year_next;
            yic_reg   <= yic_next;
            cent_reg  <= cent_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Result register: capture the date as it stands after this request
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_month_reg <= month_next;
            out_day_reg   <= day_next;
            out_year_reg  <= year_next;
            out_rej_reg   <= cmd.load_set && !set_ok;
        end
    end

    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.at_top   = at_top;

    assign cur_month = out_month_reg;
    assign cur_day   = out_day_reg;
    assign cur_year  = out_year_reg;
    assign rejected  = out_rej_reg;

endmodule

`default_nettype wire

// File: rtl/caldate_ctrl.sv
// Controller of the calendar date counter: request handshake, add loop, result handshake.
`default_nettype none

module caldate_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [1:0]            op,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output caldate_pkg::dp_cmd_t       cmd,
    input  wire caldate_pkg::dp_stat_t stat
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, accept, done;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign done     = stat.cnt_zero || stat.at_top;

    // Issue datapath commands and pick the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        caldate_pkg::OP_SET:
                        begin
                            cmd.load_set = 1'b1;
                            cmd.load_out = 1'b1;
                        end
                        caldate_pkg::OP_INC:
                        begin
                            cmd.step     = 1'b1;
                            cmd.load_out = 1'b1;
                        end
                        caldate_pkg::OP_ADD:
                        begin
                            cmd.load_cnt = 1'b1;
                            state_next   = ST_RUN;
                        end
                        default:
                        begin
                            cmd.load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // Advance one day a cycle until the count runs out or the date tops out
                if (done)
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step    = 1'b1;
                    cmd.dec_cnt = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on capture, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/calendar_date_counter.sv
// Top level of the calendar date counter: stream ports, controller and datapath.
//
// Usage:
//   Requests enter on the s_ stream. s_tuser holds the operation: set date,
//   advance one day, or advance by add_count days. Each request yields one
//   result on the m_ stream: the date after the request and a reject flag
//   that is high when a set was refused as invalid (the date then holds).
//   Set, single-day advance and the unused code capture their result as the
//   request is taken, so it is valid in the next cycle. An add of n days loads
//   the count and then advances one day per cycle through the date datapath,
//   n clamped to MAX_ADD_DAYS and cut short at 31 December 4095, then captures.
//   Throughput: one request per cycle for set and single-day advance while
//   results are taken; during an add no new request is taken.
//   Reset sets the date to 1 January 1980 and empties the result register.
//   When the receiver stalls, the result register holds; one new request is
//   taken only in the cycle the held result leaves, so no result is lost.
`default_nettype none

module calendar_date_counter #(
    parameter int MAX_ADD_DAYS = caldate_pkg::MAX_ADD_DAYS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // set_month[3:0], set_day[8:4], set_year[20:9], add_count[36:21], zero fill
    input  wire logic [39:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cur_month[3:0], cur_day[8:4], cur_year[20:9], zero fill
    output logic [23:0]      m_tdata,
    // rejected[0]
    output logic             m_tuser
);

    caldate_pkg::dp_cmd_t  cmd;
    caldate_pkg::dp_stat_t stat;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [11:0] cur_year;

    caldate_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    caldate_dp #(
        .MAX_ADD_DAYS (MAX_ADD_DAYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .set_month (s_tdata[3:0]),
        .set_day   (s_tdata[8:4]),
        .set_year  (s_tdata[20:9]),
        .add_count (s_tdata[36:21]),
        .cur_month (cur_month),
        .cur_day   (cur_day),
        .cur_year  (cur_year),
        .rejected  (m_tuser)
    );

    assign m_tdata = {3'd0, cur_year, cur_day, cur_month};

endmodule

`default_nettype wire
